// ===== rtl/core/qro_pkg.sv =====
// Shared types, widths and helpers for the quad / cell-area overlap test.
package qro_pkg;

	localparam int N_VERT        = 4;
	localparam int N_BOUND       = 2;
	localparam int VERT_W        = 24;
	localparam int TILE_W        = 15;
	localparam int NORM_W        = VERT_W + 1;
	localparam int FRAC_BITS_DEF = 8;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// Signed width of a widened cell bound: (index << frac) +/- half a cell.
	function automatic int area_w(input int frac);
		return TILE_W + frac + 1;
	endfunction

	function automatic int int_max(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== rtl/core/qro_prep.sv =====
// Stage 1: edge normals, widened area bounds and grid-axis extents of the quad.
module qro_prep
	import qro_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int AW = area_w(FRAC_BITS)
) (
	input  logic                     clk,
	input  stage_en_t                en,
	input  logic signed [VERT_W-1:0] qi [N_VERT],
	input  logic signed [VERT_W-1:0] qj [N_VERT],
	input  logic        [TILE_W-1:0] ti_lo,
	input  logic        [TILE_W-1:0] ti_hi,
	input  logic        [TILE_W-1:0] tj_lo,
	input  logic        [TILE_W-1:0] tj_hi,
	output logic signed [VERT_W-1:0] vi_s1 [N_VERT],
	output logic signed [VERT_W-1:0] vj_s1 [N_VERT],
	output logic signed [NORM_W-1:0] ni_s1 [N_VERT],
	output logic signed [NORM_W-1:0] nj_s1 [N_VERT],
	output logic signed [AW-1:0]     ai_s1 [N_BOUND],
	output logic signed [AW-1:0]     aj_s1 [N_BOUND],
	output logic signed [VERT_W-1:0] imin_s1,
	output logic signed [VERT_W-1:0] imax_s1,
	output logic signed [VERT_W-1:0] jmin_s1,
	output logic signed [VERT_W-1:0] jmax_s1
);

	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);

	logic signed [AW-1:0]     base_ilo, base_ihi, base_jlo, base_jhi;
	logic signed [VERT_W-1:0] imin_a, imin_b, imax_a, imax_b;
	logic signed [VERT_W-1:0] jmin_a, jmin_b, jmax_a, jmax_b;
	logic signed [NORM_W-1:0] ni_c [N_VERT];
	logic signed [NORM_W-1:0] nj_c [N_VERT];

	assign base_ilo = signed'({1'b0, ti_lo, {FRAC_BITS{1'b0}}});
	assign base_ihi = signed'({1'b0, ti_hi, {FRAC_BITS{1'b0}}});
	assign base_jlo = signed'({1'b0, tj_lo, {FRAC_BITS{1'b0}}});
	assign base_jhi = signed'({1'b0, tj_hi, {FRAC_BITS{1'b0}}});

	// Two-level compare trees for the axis extents
	always_comb begin
		imin_a = (qi[0] < qi[1]) ? qi[0] : qi[1];
		imin_b = (qi[2] < qi[3]) ? qi[2] : qi[3];
		imax_a = (qi[0] > qi[1]) ? qi[0] : qi[1];
		imax_b = (qi[2] > qi[3]) ? qi[2] : qi[3];
		jmin_a = (qj[0] < qj[1]) ? qj[0] : qj[1];
		jmin_b = (qj[2] < qj[3]) ? qj[2] : qj[3];
		jmax_a = (qj[0] > qj[1]) ? qj[0] : qj[1];
		jmax_b = (qj[2] > qj[3]) ? qj[2] : qj[3];
	end

	// Normal of edge k -> k+1; a zero-length edge gives a zero normal, whose
	// projections all collapse to zero and can never separate.
	for (genvar k = 0; k < N_VERT; k++) begin : g_norm
		localparam int M = (k + 1) % N_VERT;
		assign ni_c[k] = NORM_W'(qj[k]) - NORM_W'(qj[M]);
		assign nj_c[k] = NORM_W'(qi[M]) - NORM_W'(qi[k]);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			vi_s1    <= qi;
			vj_s1    <= qj;
			ni_s1    <= ni_c;
			nj_s1    <= nj_c;
			ai_s1[0] <= base_ilo - HALF;
			ai_s1[1] <= base_ihi + HALF;
			aj_s1[0] <= base_jlo - HALF;
			aj_s1[1] <= base_jhi + HALF;
			imin_s1  <= (imin_a < imin_b) ? imin_a : imin_b;
			imax_s1  <= (imax_a > imax_b) ? imax_a : imax_b;
			jmin_s1  <= (jmin_a < jmin_b) ? jmin_a : jmin_b;
			jmax_s1  <= (jmax_a > jmax_b) ? jmax_a : jmax_b;
		end
	end

endmodule

// ===== rtl/core/qro_proj.sv =====
// Stages 2-3: projection products onto each edge normal, then their sums.
module qro_proj
	import qro_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int AW  = area_w(FRAC_BITS),
	localparam int PVW = NORM_W + VERT_W,
	localparam int PAW = NORM_W + AW
) (
	input  logic                     clk,
	input  stage_en_t                en,
	input  logic signed [VERT_W-1:0] vi_s1 [N_VERT],
	input  logic signed [VERT_W-1:0] vj_s1 [N_VERT],
	input  logic signed [NORM_W-1:0] ni_s1 [N_VERT],
	input  logic signed [NORM_W-1:0] nj_s1 [N_VERT],
	input  logic signed [AW-1:0]     ai_s1 [N_BOUND],
	input  logic signed [AW-1:0]     aj_s1 [N_BOUND],
	input  logic signed [VERT_W-1:0] imin_s1,
	input  logic signed [VERT_W-1:0] imax_s1,
	input  logic signed [VERT_W-1:0] jmin_s1,
	input  logic signed [VERT_W-1:0] jmax_s1,
	output logic signed [PVW:0]      dq_s3 [N_VERT][N_VERT],
	output logic signed [PAW:0]      dt_s3 [N_VERT][N_BOUND*N_BOUND],
	output logic                     grid_apart_s3
);

	localparam int GW = int_max(VERT_W, AW);

	logic signed [PVW-1:0] pvi_s2 [N_VERT][N_VERT];
	logic signed [PVW-1:0] pvj_s2 [N_VERT][N_VERT];
	logic signed [PAW-1:0] pai_s2 [N_VERT][N_BOUND];
	logic signed [PAW-1:0] paj_s2 [N_VERT][N_BOUND];
	logic                  grid_apart_s2;
	logic                  i_apart, j_apart;

	assign i_apart = (GW'(imax_s1) < GW'(ai_s1[0])) || (GW'(imin_s1) > GW'(ai_s1[1]));
	assign j_apart = (GW'(jmax_s1) < GW'(aj_s1[0])) || (GW'(jmin_s1) > GW'(aj_s1[1]));

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < N_VERT; k++) begin
				for (int v = 0; v < N_VERT; v++) begin
					pvi_s2[k][v] <= PVW'(ni_s1[k]) * PVW'(vi_s1[v]);
					pvj_s2[k][v] <= PVW'(nj_s1[k]) * PVW'(vj_s1[v]);
				end
				for (int a = 0; a < N_BOUND; a++) begin
					pai_s2[k][a] <= PAW'(ni_s1[k]) * PAW'(ai_s1[a]);
					paj_s2[k][a] <= PAW'(nj_s1[k]) * PAW'(aj_s1[a]);
				end
			end
			grid_apart_s2 <= i_apart || j_apart;
		end
	end

	// Corner c = a*2 + b pairs i bound a with j bound b
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < N_VERT; k++) begin
				for (int v = 0; v < N_VERT; v++)
					dq_s3[k][v] <= (PVW+1)'(pvi_s2[k][v]) + (PVW+1)'(pvj_s2[k][v]);
				for (int a = 0; a < N_BOUND; a++)
					for (int b = 0; b < N_BOUND; b++)
						dt_s3[k][a*N_BOUND+b] <= (PAW+1)'(pai_s2[k][a])
							+ (PAW+1)'(paj_s2[k][b]);
			end
			grid_apart_s3 <= grid_apart_s2;
		end
	end

endmodule

// ===== rtl/core/qro_sep.sv =====
// Stages 4-5: projected intervals per edge, gap check and final verdict.
module qro_sep
	import qro_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int DQW = NORM_W + VERT_W + 1,
	localparam int DTW = NORM_W + area_w(FRAC_BITS) + 1
) (
	input  logic                  clk,
	input  stage_en_t             en,
	input  logic signed [DQW-1:0] dq_s3 [N_VERT][N_VERT],
	input  logic signed [DTW-1:0] dt_s3 [N_VERT][N_BOUND*N_BOUND],
	input  logic                  grid_apart_s3,
	output logic                  meets_s5
);

	localparam int SW = int_max(DQW, DTW);

	logic signed [DQW-1:0] qmin_c [N_VERT];
	logic signed [DQW-1:0] qmax_c [N_VERT];
	logic signed [DTW-1:0] tmin_c [N_VERT];
	logic signed [DTW-1:0] tmax_c [N_VERT];
	logic signed [DQW-1:0] qlo_a [N_VERT];
	logic signed [DQW-1:0] qlo_b [N_VERT];
	logic signed [DQW-1:0] qhi_a [N_VERT];
	logic signed [DQW-1:0] qhi_b [N_VERT];
	logic signed [DTW-1:0] tlo_a [N_VERT];
	logic signed [DTW-1:0] tlo_b [N_VERT];
	logic signed [DTW-1:0] thi_a [N_VERT];
	logic signed [DTW-1:0] thi_b [N_VERT];
	logic signed [DQW-1:0] qmin_s4 [N_VERT];
	logic signed [DQW-1:0] qmax_s4 [N_VERT];
	logic signed [DTW-1:0] tmin_s4 [N_VERT];
	logic signed [DTW-1:0] tmax_s4 [N_VERT];
	logic                  grid_apart_s4;
	logic [N_VERT-1:0]     gap;

	always_comb begin
		for (int k = 0; k < N_VERT; k++) begin
			qlo_a[k]  = (dq_s3[k][0] < dq_s3[k][1]) ? dq_s3[k][0] : dq_s3[k][1];
			qlo_b[k]  = (dq_s3[k][2] < dq_s3[k][3]) ? dq_s3[k][2] : dq_s3[k][3];
			qhi_a[k]  = (dq_s3[k][0] > dq_s3[k][1]) ? dq_s3[k][0] : dq_s3[k][1];
			qhi_b[k]  = (dq_s3[k][2] > dq_s3[k][3]) ? dq_s3[k][2] : dq_s3[k][3];
			tlo_a[k]  = (dt_s3[k][0] < dt_s3[k][1]) ? dt_s3[k][0] : dt_s3[k][1];
			tlo_b[k]  = (dt_s3[k][2] < dt_s3[k][3]) ? dt_s3[k][2] : dt_s3[k][3];
			thi_a[k]  = (dt_s3[k][0] > dt_s3[k][1]) ? dt_s3[k][0] : dt_s3[k][1];
			thi_b[k]  = (dt_s3[k][2] > dt_s3[k][3]) ? dt_s3[k][2] : dt_s3[k][3];
			qmin_c[k] = (qlo_a[k] < qlo_b[k]) ? qlo_a[k] : qlo_b[k];
			qmax_c[k] = (qhi_a[k] > qhi_b[k]) ? qhi_a[k] : qhi_b[k];
			tmin_c[k] = (tlo_a[k] < tlo_b[k]) ? tlo_a[k] : tlo_b[k];
			tmax_c[k] = (thi_a[k] > thi_b[k]) ? thi_a[k] : thi_b[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			qmin_s4       <= qmin_c;
			qmax_s4       <= qmax_c;
			tmin_s4       <= tmin_c;
			tmax_s4       <= tmax_c;
			grid_apart_s4 <= grid_apart_s3;
		end
	end

	// Only a strict gap separates; touching intervals count as overlap
	always_comb begin
		for (int k = 0; k < N_VERT; k++)
			gap[k] = (SW'(qmax_s4[k]) < SW'(tmin_s4[k]))
				|| (SW'(qmin_s4[k]) > SW'(tmax_s4[k]));
	end

	always_ff @(posedge clk) begin
		if (en.s5)
			meets_s5 <= !grid_apart_s4 && !(|gap);
	end

endmodule

// ===== rtl/core/quad_rect_overlap_test.sv =====
// Top level: separating axis test of a convex quad against a widened cell area.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, quad_i0..3, quad_j0..3,      | to block
//           | tile_i_low, tile_i_high, tile_j_low, tile_j_high |
//   out     | out_valid, out_ready, meets                      | from block
//
// Five register stages (prep, products, sums, min/max, verdict): while out_ready is high
// every stage takes a new transaction each cycle, so one transaction per cycle when the
// output does not stall. The 25 x 24 bit products set the critical path. Reset clears only the stage
// valid bits. A stalled output holds each occupied stage; empty stages keep filling, so
// in_ready drops only when all five stages hold a transaction and out_ready is low.
module quad_rect_overlap_test
	import qro_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [VERT_W-1:0] quad_i0,
	input  logic signed [VERT_W-1:0] quad_i1,
	input  logic signed [VERT_W-1:0] quad_i2,
	input  logic signed [VERT_W-1:0] quad_i3,
	input  logic signed [VERT_W-1:0] quad_j0,
	input  logic signed [VERT_W-1:0] quad_j1,
	input  logic signed [VERT_W-1:0] quad_j2,
	input  logic signed [VERT_W-1:0] quad_j3,
	input  logic        [TILE_W-1:0] tile_i_low,
	input  logic        [TILE_W-1:0] tile_i_high,
	input  logic        [TILE_W-1:0] tile_j_low,
	input  logic        [TILE_W-1:0] tile_j_high,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     meets
);

	localparam int AW  = area_w(FRAC_BITS);
	localparam int PVW = NORM_W + VERT_W;
	localparam int PAW = NORM_W + AW;

	stage_en_t adv;
	logic      v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [VERT_W-1:0] qi [N_VERT];
	logic signed [VERT_W-1:0] qj [N_VERT];
	logic signed [VERT_W-1:0] vi_s1 [N_VERT];
	logic signed [VERT_W-1:0] vj_s1 [N_VERT];
	logic signed [NORM_W-1:0] ni_s1 [N_VERT];
	logic signed [NORM_W-1:0] nj_s1 [N_VERT];
	logic signed [AW-1:0]     ai_s1 [N_BOUND];
	logic signed [AW-1:0]     aj_s1 [N_BOUND];
	logic signed [VERT_W-1:0] imin_s1, imax_s1, jmin_s1, jmax_s1;
	logic signed [PVW:0]      dq_s3 [N_VERT][N_VERT];
	logic signed [PAW:0]      dt_s3 [N_VERT][N_BOUND*N_BOUND];
	logic                     grid_apart_s3;

	assign qi[0] = quad_i0;
	assign qi[1] = quad_i1;
	assign qi[2] = quad_i2;
	assign qi[3] = quad_i3;
	assign qj[0] = quad_j0;
	assign qj[1] = quad_j1;
	assign qj[2] = quad_j2;
	assign qj[3] = quad_j3;

	// A stage may load when it is empty or its contents move on
	always_comb begin
		adv.s5 = !v_s5 || out_ready;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign in_ready  = adv.s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= in_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
		end
	end

	qro_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk     (clk),
		.en      (adv),
		.qi      (qi),
		.qj      (qj),
		.ti_lo   (tile_i_low),
		.ti_hi   (tile_i_high),
		.tj_lo   (tile_j_low),
		.tj_hi   (tile_j_high),
		.vi_s1   (vi_s1),
		.vj_s1   (vj_s1),
		.ni_s1   (ni_s1),
		.nj_s1   (nj_s1),
		.ai_s1   (ai_s1),
		.aj_s1   (aj_s1),
		.imin_s1 (imin_s1),
		.imax_s1 (imax_s1),
		.jmin_s1 (jmin_s1),
		.jmax_s1 (jmax_s1)
	);

	qro_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
		.clk           (clk),
		.en            (adv),
		.vi_s1         (vi_s1),
		.vj_s1         (vj_s1),
		.ni_s1         (ni_s1),
		.nj_s1         (nj_s1),
		.ai_s1         (ai_s1),
		.aj_s1         (aj_s1),
		.imin_s1       (imin_s1),
		.imax_s1       (imax_s1),
		.jmin_s1       (jmin_s1),
		.jmax_s1       (jmax_s1),
		.dq_s3         (dq_s3),
		.dt_s3         (dt_s3),
		.grid_apart_s3 (grid_apart_s3)
	);

	qro_sep #(.FRAC_BITS(FRAC_BITS)) u_sep (
		.clk           (clk),
		.en            (adv),
		.dq_s3         (dq_s3),
		.dt_s3         (dt_s3),
		.grid_apart_s3 (grid_apart_s3),
		.meets_s5      (meets)
	);

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction did not enter stage 1");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !adv.s4 |=> v_s3)
		else $error("stalled stage 3 lost its transaction");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready)
		else $error("input stalled while the pipeline had room");

	a_drain_empties_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !v_s4 |=> !out_valid)
		else $error("result repeated after its transaction completed");

endmodule
